[rtl/core/sibct_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package sibct_pkg;
    localparam int BUCKETS      = 256;
    localparam int WAYS         = 4;
    localparam int COUNTER_BITS = 64;
    localparam int BKT_W        = $clog2(BUCKETS);
    localparam int WAY_W        = (WAYS > 1) ? $clog2(WAYS) : 1;

    localparam logic [1:0] ST_COUNTED = 2'd0;
    localparam logic [1:0] ST_SKIPPED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic CFG_LOCAL_MAC   = 1'b0;
    localparam logic CFG_COUNT_LOCAL = 1'b1;

    typedef struct packed {
        logic clear;
        logic load;
        logic lookup;
        logic finish;
    } t_ctl;

    typedef struct packed {
        logic skip;
        logic clr_last;
    } t_sts;

    typedef struct packed {
        logic [47:0]             mac;
        logic [63:0]             hi;
        logic [63:0]             lo;
        logic                    v6;
        logic [COUNTER_BITS-1:0] up;
        logic [COUNTER_BITS-1:0] down;
    } t_entry;
endpackage
`default_nettype wire

[rtl/core/sibct_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module sibct_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire sibct_pkg::t_sts i_sts,
    output sibct_pkg::t_ctl    o_ctl,
    output logic               o_busy
);
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_UPD   = 2'd2;
    localparam logic [1:0] S_CLEAR = 2'd3;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                if (i_sts.skip) begin
                    o_ctl.finish = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_ctl.lookup = 1'b1;
                    n_state      = S_UPD;
                end
            end
            S_UPD: begin
                o_ctl.finish = 1'b1;
                n_state      = S_IDLE;
            end
            S_CLEAR: begin
                o_ctl.clear = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else          r_state <= n_state;
    end

    assign o_busy = (r_state != S_IDLE);

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |-> r_state == S_IDLE) else $error("load outside idle");
    a_lookup_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.lookup |=> r_state == S_UPD) else $error("lookup not followed by update");
    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.finish |=> r_state == S_IDLE) else $error("finish not idle");
endmodule
`default_nettype wire

[rtl/core/sibct_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module sibct_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sibct_pkg::t_ctl   i_ctl,
    output sibct_pkg::t_sts        o_sts,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic [47:0]       i_cfg_data,
    input  wire logic [47:0]       i_station_mac,
    input  wire logic [63:0]       i_ip_high,
    input  wire logic [63:0]       i_ip_low,
    input  wire logic              i_is_ipv6,
    input  wire logic [15:0]       i_byte_count,
    input  wire logic              i_direction,
    output logic                   o_valid,
    output logic [1:0]             o_status,
    output logic [9:0]             o_slot,
    output logic                   o_created,
    output logic [63:0]            o_up_total,
    output logic [63:0]            o_down_total
);
    localparam int CB = sibct_pkg::COUNTER_BITS;
    localparam int W  = sibct_pkg::WAYS;
    localparam int EW = $bits(sibct_pkg::t_entry);

    logic [47:0] r_local_mac;
    logic        r_count_local;
    logic [47:0] r_mac;
    logic [63:0] r_hi, r_lo;
    logic        r_v6, r_dir;
    logic [15:0] r_amt;
    logic [sibct_pkg::BKT_W-1:0] r_bkt;
    logic [sibct_pkg::BKT_W-1:0] r_clr;

    logic [EW-1:0] r_mem [sibct_pkg::BUCKETS][W];
    logic [W-1:0]  r_vld [sibct_pkg::BUCKETS];
    logic [EW-1:0] r_rd  [W];
    logic [W-1:0]  r_rdv;

    logic                         r_cre, r_ok;
    logic [sibct_pkg::WAY_W-1:0]  r_way;
    sibct_pkg::t_entry            r_ent;

    logic [9:0] sum;
    always_comb begin
        sum = 10'(i_station_mac[7:0]) + 10'(i_station_mac[15:8])
            + 10'(i_station_mac[23:16]) + 10'(i_station_mac[31:24])
            + 10'(i_station_mac[39:32]) + 10'(i_station_mac[47:40]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_mac   <= '0;
            r_count_local <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == sibct_pkg::CFG_LOCAL_MAC) r_local_mac <= i_cfg_data;
            else                                       r_count_local <= i_cfg_data[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)         r_clr <= '0;
        else if (i_ctl.clear) r_clr <= r_clr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mac <= i_station_mac;
            r_v6  <= i_is_ipv6;
            r_hi  <= i_is_ipv6 ? i_ip_high : 64'd0;
            r_lo  <= i_is_ipv6 ? i_ip_low : {32'd0, i_ip_low[31:0]};
            r_amt <= i_byte_count;
            r_dir <= i_direction;
            r_bkt <= sibct_pkg::BKT_W'(sum);
            for (int k = 0; k < W; k++) r_rd[k] <= r_mem[sibct_pkg::BKT_W'(sum)][k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) r_rdv <= r_vld[sibct_pkg::BKT_W'(sum)];
    end

    always_comb begin
        o_sts.skip     = !r_count_local && (r_mac == r_local_mac);
        o_sts.clr_last = (r_clr == sibct_pkg::BKT_W'(sibct_pkg::BUCKETS - 1));
    end

    logic [W-1:0] match;
    sibct_pkg::t_entry re [W];
    always_comb begin
        for (int k = 0; k < W; k++) begin
            re[k]    = sibct_pkg::t_entry'(r_rd[k]);
            match[k] = r_rdv[k] && re[k].mac == r_mac && re[k].v6 == r_v6
                       && re[k].hi == r_hi && re[k].lo == r_lo;
        end
    end

    logic                        hit, fre;
    logic [sibct_pkg::WAY_W-1:0] hway, fway;
    always_comb begin
        hit = 1'b0; fre = 1'b0; hway = '0; fway = '0;
        for (int k = W - 1; k >= 0; k--) begin
            if (match[k]) begin
                hit  = 1'b1;
                hway = sibct_pkg::WAY_W'(k);
            end
            if (!r_rdv[k]) begin
                fre  = 1'b1;
                fway = sibct_pkg::WAY_W'(k);
            end
        end
    end

    sibct_pkg::t_entry sel;
    always_comb begin
        sel = re[hway];
        if (!hit) begin
            sel.mac  = r_mac;
            sel.v6   = r_v6;
            sel.hi   = r_hi;
            sel.lo   = r_lo;
            sel.up   = '0;
            sel.down = '0;
        end
    end

    logic [CB:0] add_in, add_s;
    logic [CB-1:0] newc;
    always_comb begin
        add_in = {1'b0, (r_dir ? sel.down : sel.up)};
        add_s  = add_in + (CB+1)'(r_amt);
        newc   = add_s[CB] ? {CB{1'b1}} : add_s[CB-1:0];
    end

    sibct_pkg::t_entry upd;
    always_comb begin
        upd = sel;
        if (r_dir) upd.down = newc;
        else       upd.up   = newc;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.lookup) begin
            r_ok  <= hit || fre;
            r_cre <= !hit;
            r_way <= hit ? hway : fway;
            r_ent <= upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.finish && !o_sts.skip && r_ok) r_mem[r_bkt][r_way] <= EW'(r_ent);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_vld[r_clr] <= '0;
        end else if (i_ctl.finish && !o_sts.skip && r_ok) begin
            r_vld[r_bkt][r_way] <= 1'b1;
        end
    end

    logic       r_val;
    logic [1:0] r_st;
    logic [9:0] r_sl;
    logic       r_cr;
    logic [63:0] r_up, r_dn;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_val <= 1'b0;
        else          r_val <= i_ctl.finish;
    end
    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            if (o_sts.skip) begin
                r_st <= sibct_pkg::ST_SKIPPED;
                r_sl <= '0; r_cr <= 1'b0; r_up <= '0; r_dn <= '0;
            end else if (!r_ok) begin
                r_st <= sibct_pkg::ST_FULL;
                r_sl <= '0; r_cr <= 1'b0; r_up <= '0; r_dn <= '0;
            end else begin
                r_st <= sibct_pkg::ST_COUNTED;
                r_sl <= 10'(r_bkt * W + r_way);
                r_cr <= r_cre;
                r_up <= 64'(r_ent.up);
                r_dn <= 64'(r_ent.down);
            end
        end
    end

    assign o_valid      = r_val;
    assign o_status     = r_st;
    assign o_slot       = r_sl;
    assign o_created    = r_cr;
    assign o_up_total   = r_up;
    assign o_down_total = r_dn;

    a_hit_notcre: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.lookup && hit |=> !r_cre) else $error("hit marked created");
    a_out_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_ctl.finish)) else $error("stray result");
    a_sel_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.lookup |-> !i_ctl.load && !i_ctl.finish) else $error("overlap cmd");
endmodule
`default_nettype wire

[rtl/core/station_ip_byte_counter_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// A packet is accepted in idle and its bucket is read into registers. A skipped packet
// finishes from the read state; any other one registers the way compare, then its
// update state makes the single write-back of one row. Busy gates start until done.
// Results are one-cycle strobes; the receiver cannot stall.
// Synchronous active-low reset clears the registers, then a clearing pass over all 256
// buckets empties the table with busy held high.
module station_ip_byte_counter_table (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [47:0] i_cfg_data,
    input  wire logic [47:0] i_station_mac,
    input  wire logic [63:0] i_ip_high,
    input  wire logic [63:0] i_ip_low,
    input  wire logic        i_is_ipv6,
    input  wire logic [15:0] i_byte_count,
    input  wire logic        i_direction,
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic [9:0]       o_slot,
    output logic             o_created,
    output logic [63:0]      o_up_total,
    output logic [63:0]      o_down_total
);
    sibct_pkg::t_ctl ctl;
    sibct_pkg::t_sts sts;

    assign o_cfg_ready = !busy && !start;

    sibct_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_sts(sts), .o_ctl(ctl), .o_busy(busy)
    );

    sibct_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .o_sts(sts),
        .i_cfg_we(i_cfg_valid && o_cfg_ready), .i_cfg_idx(i_cfg_index[0]),
        .i_cfg_data(i_cfg_data),
        .i_station_mac(i_station_mac), .i_ip_high(i_ip_high), .i_ip_low(i_ip_low),
        .i_is_ipv6(i_is_ipv6), .i_byte_count(i_byte_count), .i_direction(i_direction),
        .o_valid(o_valid), .o_status(o_status), .o_slot(o_slot), .o_created(o_created),
        .o_up_total(o_up_total), .o_down_total(o_down_total)
    );
endmodule
`default_nettype wire
